// ===== rtl/core/msd_pkg.sv =====
// shared types, constants and the digit pattern table of the seven-segment driver
// no dependencies; every other file of the block imports this package
`default_nettype none

package msd_pkg;

  localparam int unsigned NUM_DIGITS_DEF = 4;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned VALUE_W        = 14;
  localparam int unsigned SEG_W          = 8;
  localparam int unsigned DP_W           = 2;
  localparam int unsigned DIGIT_W        = 2;
  localparam int unsigned FRAME_W        = 16;
  localparam int unsigned FRAME_CNT_W    = 4;
  localparam int unsigned FIFO_DEPTH     = 2;

  localparam logic [FRAME_CNT_W-1:0] FRAME_LAST = FRAME_CNT_W'(FRAME_W - 1);

  localparam logic [SEG_W-1:0] SEG_OFF      = 8'hFF;
  localparam logic [SEG_W-1:0] SEG_ALL_ON   = 8'h00;
  localparam logic [SEG_W-1:0] SEG_ZERO     = 8'hC0;
  localparam logic [SEG_W-1:0] SEG_DOT_MASK = 8'h7F;
  localparam logic [SEG_W-1:0] SEG_ONLY_DOT = 8'h7F;

  localparam logic [DP_W-1:0] DP_RESET = 2'd2;

  // floor(v / 10) == (v * 52429) >> 19 for every 16-bit v
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef enum logic [MODE_W-1:0] {
    MODE_DECIMAL = 3'd0,
    MODE_DOTS    = 3'd1,
    MODE_ALL_OFF = 3'd2,
    MODE_ALL_ON  = 3'd3,
    MODE_TICK    = 3'd4
  } mode_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    FS_IDLE = 2'd0,
    FS_CONV = 2'd1,
    FS_PUSH = 2'd2
  } front_state_e;

  typedef struct packed {
    logic not_empty;
    logic full;
  } fifo_status_t;

  function automatic logic [SEG_W-1:0] digit_pattern(input logic [3:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 8'hC0;
      4'd1:    p = 8'hF9;
      4'd2:    p = 8'hA4;
      4'd3:    p = 8'hB0;
      4'd4:    p = 8'h99;
      4'd5:    p = 8'h92;
      4'd6:    p = 8'h82;
      4'd7:    p = 8'hF8;
      4'd8:    p = 8'h80;
      4'd9:    p = 8'h90;
      default: p = SEG_OFF;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/msd_cmd_if.sv =====
// command channel: mode and value with valid/ready
// depends on msd_pkg for field widths
`default_nettype none

interface msd_cmd_if import msd_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/msd_cfg_if.sv =====
// configuration write channel carrying the decimal point digit
// depends on msd_pkg for field widths
`default_nettype none

interface msd_cfg_if import msd_pkg::*;;
  logic            valid;
  logic            ready;
  logic [DP_W-1:0] decimal_point_digit;

  modport source (output valid, output decimal_point_digit, input ready);
  modport sink   (input valid, input decimal_point_digit, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/msd_out_if.sv =====
// serial output channel: one frame bit per request with valid/ready
// depends on msd_pkg for field widths
`default_nettype none

interface msd_out_if import msd_pkg::*;;
  logic               valid;
  logic               ready;
  logic               serial_bit;
  logic               latch_after;
  logic [DIGIT_W-1:0] digit_shown;

  modport source (output valid, output serial_bit, output latch_after, output digit_shown,
                  input ready);
  modport sink   (input valid, input serial_bit, input latch_after, input digit_shown,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/msd_fifo.sv =====
// short command queue between the front decoder and the back end
// depends on msd_pkg for the status struct
`default_nettype none

module msd_fifo import msd_pkg::*; #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output fifo_status_t     status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o            = mem_q[rptr_q];
  assign status_o.not_empty = (cnt_q != '0);
  assign status_o.full      = (cnt_q == CntW'(Depth));

endmodule

`default_nettype wire

// ===== rtl/core/msd_front.sv =====
// front end: takes commands, converts decimal values digit by digit, builds segment loads
// depends on msd_pkg, msd_cmd_if and msd_cfg_if
`default_nettype none

module msd_front import msd_pkg::*; #(
  parameter int unsigned NumDigits = NUM_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  msd_cmd_if.sink                      cmd,
  msd_cfg_if.sink                      cfg,
  input  fifo_status_t                 fifo_st_i,
  output logic                         push_o,
  output cmd_e                         push_kind_o,
  output logic [NumDigits*SEG_W-1:0]   push_segs_o
);

  localparam int unsigned IdxW = $clog2(NumDigits);

  front_state_e       state_q, state_d;
  logic [IdxW-1:0]    pos_q;
  logic [VALUE_W-1:0] val_q;
  logic [SEG_W-1:0]   segs_q [NumDigits];
  logic [DP_W-1:0]    dp_q;

  logic               accept;
  logic               conv_busy;
  logic [29:0]        prod;
  logic [10:0]        quo;
  logic [VALUE_W-1:0] rem_full;
  logic [SEG_W-1:0]   out_segs [NumDigits];

  assign conv_busy = (state_q != FS_IDLE);
  assign cmd.ready = !conv_busy && !fifo_st_i.full;
  assign accept    = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  // one decimal digit per cycle through a reciprocal multiply
  assign prod     = 30'(val_q) * 30'(DIV10_MUL);
  assign quo      = prod[DIV10_SHIFT +: 11];
  assign rem_full = val_q - VALUE_W'({quo, 3'b000}) - VALUE_W'({quo, 1'b0});

  always_comb begin
    state_d = state_q;
    case (state_q)
      FS_IDLE: begin
        if (accept && cmd.mode == MODE_DECIMAL) begin
          state_d = FS_CONV;
        end
      end
      FS_CONV: begin
        if (pos_q == '0) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!fifo_st_i.full) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_comb begin
    logic keep;
    push_o      = 1'b0;
    push_kind_o = CMD_LOAD;
    keep        = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      out_segs[i] = SEG_OFF;
    end
    case (state_q)
      FS_IDLE: begin
        if (accept) begin
          case (cmd.mode)
            MODE_DOTS: begin
              push_o = 1'b1;
              for (int i = 0; i < NumDigits; i++) begin
                out_segs[i] = cmd.value[NumDigits-1-i] ? SEG_ONLY_DOT : SEG_OFF;
              end
            end
            MODE_ALL_OFF: begin
              push_o = 1'b1;
            end
            MODE_ALL_ON: begin
              push_o = 1'b1;
              for (int i = 0; i < NumDigits; i++) begin
                out_segs[i] = SEG_ALL_ON;
              end
            end
            MODE_TICK: begin
              push_o      = 1'b1;
              push_kind_o = CMD_TICK;
            end
            default: push_o = 1'b0;
          endcase
        end
      end
      FS_PUSH: begin
        push_o = !fifo_st_i.full;
        for (int i = 0; i < NumDigits; i++) begin
          out_segs[i] = segs_q[i];
          if (32'(dp_q) == i) begin
            out_segs[i] = segs_q[i] & SEG_DOT_MASK;
          end
        end
        // blank leading plain zeros, stop at the first other pattern
        for (int i = 0; i < NumDigits; i++) begin
          if (keep && out_segs[i] == SEG_ZERO) begin
            out_segs[i] = SEG_OFF;
          end else begin
            keep = 1'b0;
          end
        end
      end
      default: push_o = 1'b0;
    endcase
  end

  for (genvar g = 0; g < NumDigits; g++) begin : g_pack
    assign push_segs_o[g*SEG_W +: SEG_W] = out_segs[g];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      pos_q   <= '0;
      dp_q    <= DP_RESET;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pos_q <= IdxW'(NumDigits - 1);
      end else if (state_q == FS_CONV) begin
        pos_q <= pos_q - 1'b1;
      end
      if (cfg.valid) begin
        dp_q <= cfg.decimal_point_digit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q <= cmd.value;
    end else if (state_q == FS_CONV) begin
      val_q         <= VALUE_W'(quo);
      segs_q[pos_q] <= digit_pattern(rem_full[3:0]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msd_back.sv =====
// back end: segment store, scan position and the 16-bit frame serializer
// depends on msd_pkg and msd_out_if
`default_nettype none

module msd_back import msd_pkg::*; #(
  parameter int unsigned NumDigits = NUM_DIGITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fifo_status_t               fifo_st_i,
  input  cmd_e                       head_kind_i,
  input  logic [NumDigits*SEG_W-1:0] head_segs_i,
  output logic                       pop_o,
  msd_out_if.source                  out
);

  localparam int unsigned IdxW = $clog2(NumDigits);

  logic [SEG_W-1:0]       seg_q [NumDigits];
  logic [IdxW-1:0]        scan_q, scan_next;
  logic                   active_q;
  logic [FRAME_CNT_W-1:0] cnt_q;
  logic [FRAME_W-1:0]     shift_q;
  logic [DIGIT_W-1:0]     digit_q;
  logic                   out_valid_q, out_bit_q, out_latch_q;
  logic [DIGIT_W-1:0]     out_digit_q;

  logic                   emit, last, start, load;
  logic [FRAME_W-1:0]     frame;
  logic [2:0]             scan_ext;

  assign emit  = active_q && (!out_valid_q || out.ready);
  assign last  = (cnt_q == FRAME_LAST);
  assign load  = fifo_st_i.not_empty && head_kind_i == CMD_LOAD;
  // a tick at the queue head starts a frame when the serializer is idle, or as the last bit of the current one leaves
  assign start = fifo_st_i.not_empty && head_kind_i == CMD_TICK &&
                 (!active_q || (emit && last));
  assign pop_o = start || load;

  assign frame     = {seg_q[scan_q], SEG_W'(1) << scan_q};
  assign scan_next = (scan_q == IdxW'(NumDigits - 1)) ? '0 : scan_q + 1'b1;
  assign scan_ext  = 3'(scan_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) begin
        seg_q[i] <= SEG_OFF;
      end
      scan_q      <= '0;
      active_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        for (int i = 0; i < NumDigits; i++) begin
          seg_q[i] <= head_segs_i[i*SEG_W +: SEG_W];
        end
      end
      if (start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
        scan_q   <= scan_next;
      end else if (emit) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          active_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      shift_q <= frame;
      digit_q <= scan_ext[DIGIT_W-1:0];
    end else if (emit) begin
      shift_q <= {shift_q[FRAME_W-2:0], 1'b0};
    end
    if (emit) begin
      out_bit_q   <= shift_q[FRAME_W-1];
      out_latch_q <= last;
      out_digit_q <= digit_q;
    end
  end

  assign out.valid       = out_valid_q;
  assign out.serial_bit  = out_bit_q;
  assign out.latch_after = out_latch_q;
  assign out.digit_shown = out_digit_q;

  a_latch_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && last |=> out_latch_q)
    else $error("latch flag missing on the last frame bit");

  a_no_early_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !last |=> !out_latch_q)
    else $error("latch flag raised before the last frame bit");

  a_start_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> active_q && cnt_q == '0)
    else $error("frame did not start at bit zero");

endmodule

`default_nettype wire

// ===== rtl/core/multiplexed_seven_segment_driver.sv =====
// top level of the multiplexed seven-segment driver
// depends on msd_pkg, the channel interfaces, msd_front, msd_fifo and msd_back
//
// Usage:
//   cmd_i carries one request of mode and value. Decimal, dots, all-off and all-on
//   requests rewrite the per-digit segment bytes (active low, bit 7 is the dot).
//   A refresh tick sends the current digit's 16-bit frame on out_o, one bit per
//   request, most significant first: segment byte, then the one-hot digit select.
//   latch_after marks the sixteenth bit; the scan moves on as each frame is loaded.
//   cfg_i writes the decimal point digit; write it only while the block is idle.
// Timing:
//   a tick's first bit passes the queue, the frame shift register and the output
//   register; after that comes one bit per cycle while out_o is ready, and ticks
//   queue up so frames follow with no gap. A decimal request holds the front from
//   its acceptance through the conversion, one digit per cycle, and then the push,
//   which waits while the queue is full; other requests leave the front free.
//   A two-entry queue sits between the converter and the serializer.
// Reset: all digits dark, scan at digit 0, decimal point digit 2.
// When out_o stalls, the current bit holds and the serializer waits; the front
//   keeps taking requests until the queue fills.
`default_nettype none

module multiplexed_seven_segment_driver import msd_pkg::*; #(
  parameter int unsigned NumDigits = NUM_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msd_cmd_if.sink    cmd_i,
  msd_cfg_if.sink    cfg_i,
  msd_out_if.source  out_o
);

  localparam int unsigned SegsW  = NumDigits * SEG_W;
  localparam int unsigned EntryW = SegsW + 1;

  fifo_status_t      fifo_st;
  logic              push, pop;
  cmd_e              push_kind;
  logic [SegsW-1:0]  push_segs;
  logic [EntryW-1:0] head;

  msd_front #(.NumDigits(NumDigits)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd         (cmd_i),
    .cfg         (cfg_i),
    .fifo_st_i   (fifo_st),
    .push_o      (push),
    .push_kind_o (push_kind),
    .push_segs_o (push_segs)
  );

  msd_fifo #(.Width(EntryW), .Depth(FIFO_DEPTH)) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  ({push_kind, push_segs}),
    .pop_i    (pop),
    .rdata_o  (head),
    .status_o (fifo_st)
  );

  msd_back #(.NumDigits(NumDigits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_st_i   (fifo_st),
    .head_kind_i (cmd_e'(head[EntryW-1])),
    .head_segs_i (head[SegsW-1:0]),
    .pop_o       (pop),
    .out         (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/multiplexed_seven_segment_driver_tb.sv =====
// testbench for the multiplexed seven-segment driver: directed and random requests,
// serial frame bits checked against a local model of the digit store and scan
// depends on msd_pkg, msd_cmd_if, msd_cfg_if, msd_out_if and the top level
`timescale 1ns / 100ps

module multiplexed_seven_segment_driver_tb;
  import msd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned TAIL_CYCLES   = 40;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PRINT_LIMIT   = 40;

  localparam logic [SEG_W-1:0] GLYPH [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  typedef struct packed {
    logic               serial_bit;
    logic               latch_after;
    logic [DIGIT_W-1:0] digit_shown;
  } frame_bit_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  msd_cmd_if cmd_if ();
  msd_cfg_if cfg_if ();
  msd_out_if out_if ();

  multiplexed_seven_segment_driver u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // local copy of the display store, scan and decimal point setting
  logic [SEG_W-1:0]   shown_segments [NUM_DIGITS_DEF];
  logic [DIGIT_W-1:0] scan_digit;
  logic [DP_W-1:0]    point_digit;
  frame_bit_t         frame_bits_due [$];

  int sender_gap_pct     = 0;
  int receiver_stall_pct = 0;
  int error_count        = 0;
  int update_count       = 0;
  int tick_count         = 0;
  int ignored_count      = 0;
  int bits_checked       = 0;
  int idle_cycles        = 0;

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("[%0t] error: %s", $time, msg);
    error_count++;
  endtask

  // update the display model for one accepted request, queue the frame bits of a tick
  function automatic void apply_request(input logic [MODE_W-1:0] mode,
                                        input logic [VALUE_W-1:0] value);
    int unsigned rest;
    int i;
    logic [FRAME_W-1:0] frame;
    frame_bit_t fb;
    case (mode)
      MODE_DECIMAL: begin
        rest = 32'(value);
        for (i = NUM_DIGITS_DEF - 1; i >= 0; i--) begin
          shown_segments[i] = GLYPH[rest % 10];
          rest = rest / 10;
        end
        shown_segments[point_digit][SEG_W-1] = 1'b0;
        // leading plain zeros go dark, stopping at the first other pattern
        i = 0;
        while (i < NUM_DIGITS_DEF && shown_segments[i] == SEG_ZERO) begin
          shown_segments[i] = SEG_OFF;
          i++;
        end
      end
      MODE_DOTS: begin
        for (i = 0; i < NUM_DIGITS_DEF; i++)
          shown_segments[i] = value[NUM_DIGITS_DEF-1-i] ? SEG_ONLY_DOT : SEG_OFF;
      end
      MODE_ALL_OFF: begin
        for (i = 0; i < NUM_DIGITS_DEF; i++) shown_segments[i] = SEG_OFF;
      end
      MODE_ALL_ON: begin
        for (i = 0; i < NUM_DIGITS_DEF; i++) shown_segments[i] = SEG_ALL_ON;
      end
      MODE_TICK: begin
        frame = {shown_segments[scan_digit], SEG_W'(1 << scan_digit)};
        for (i = 0; i < FRAME_W; i++) begin
          fb.serial_bit  = frame[FRAME_W-1-i];
          fb.latch_after = (i == FRAME_W - 1);
          fb.digit_shown = scan_digit;
          frame_bits_due.push_back(fb);
        end
        scan_digit = scan_digit + 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < sender_gap_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.mode  <= mode;
    cmd_if.value <= value;
    do @(posedge clk_i); while (!cmd_if.ready);
    apply_request(mode, value);
    if (mode == MODE_TICK) tick_count++;
    else if (mode > MODE_TICK) ignored_count++;
    else update_count++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_request(MODE_TICK, VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1)));
  endtask

  // block goes quiet: all frame bits seen, then time for queued loads to finish
  task automatic wait_until_drained();
    cmd_if.valid <= 1'b0;
    while (frame_bits_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_decimal_point(input logic [DP_W-1:0] digit);
    cfg_if.valid               <= 1'b1;
    cfg_if.decimal_point_digit <= digit;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    point_digit = digit;
  endtask

  task automatic test_directed();
    logic [MODE_W-1:0] m;
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    // display after reset, decimal point at its reset digit
    send_ticks(NUM_DIGITS_DEF);
    send_request(MODE_DECIMAL, '1);
    send_ticks(NUM_DIGITS_DEF);
    // zero with the point on the first digit: nothing is blanked
    wait_until_drained();
    write_decimal_point(2'd0);
    send_request(MODE_DECIMAL, '0);
    send_ticks(NUM_DIGITS_DEF);
    // five-digit value shows only its low zeros, point on the last digit: three leading digits blank
    wait_until_drained();
    write_decimal_point(2'd3);
    send_request(MODE_DECIMAL, VALUE_W'(10000));
    send_ticks(NUM_DIGITS_DEF);
    send_request(MODE_DOTS, VALUE_W'(4'b1010));
    send_ticks(2);
    send_request(MODE_ALL_ON, '1);
    // unused codes leave the display alone
    for (m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST && m >= MODE_UNUSED_FIRST; m++)
      send_request(m, '1);
    send_ticks(1);
    send_request(MODE_ALL_OFF, '0);
    send_ticks(1);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                     input logic [DP_W-1:0] digit, input int count);
    int done;
    int pick;
    logic [VALUE_W-1:0] v;
    done = 0;
    wait_until_drained();
    write_decimal_point(digit);
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
    while (done < count) begin
      pick = $urandom_range(99);
      v    = VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
      if (pick < 38) begin
        send_request(MODE_TICK, v);
      end else if (pick < 60) begin
        // small values half the time so leading-zero blanking shows up often
        send_request(MODE_DECIMAL, $urandom_range(1) ? v : VALUE_W'($urandom_range(0, 120)));
      end else if (pick < 72) begin
        send_request(MODE_DOTS, v);
      end else if (pick < 78) begin
        send_request(MODE_ALL_OFF, v);
      end else if (pick < 84) begin
        send_request(MODE_ALL_ON, v);
      end else if (pick < 94) begin
        // an update followed by a full scan of the display
        send_request(MODE_DECIMAL, v);
        send_ticks(NUM_DIGITS_DEF);
        done += NUM_DIGITS_DEF;
      end else begin
        send_request(MODE_UNUSED_FIRST + MODE_W'($urandom_range(0, 2)), v);
        continue;
      end
      done++;
    end
  endtask

  // result checker, one frame bit per request on the output channel
  always @(posedge clk_i) begin
    frame_bit_t got;
    frame_bit_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.serial_bit, out_if.latch_after, out_if.digit_shown};
      if (frame_bits_due.size() == 0) begin
        report_mismatch($sformatf("unexpected bit %b latch %b digit %0d",
                                  got.serial_bit, got.latch_after, got.digit_shown));
      end else begin
        want = frame_bits_due.pop_front();
        bits_checked++;
        if (got.serial_bit !== want.serial_bit)
          report_mismatch($sformatf("serial_bit %b, want %b", got.serial_bit, want.serial_bit));
        if (got.latch_after !== want.latch_after)
          report_mismatch($sformatf("latch_after %b, want %b",
                                    got.latch_after, want.latch_after));
        if (got.digit_shown !== want.digit_shown)
          report_mismatch($sformatf("digit_shown %0d, want %0d",
                                    got.digit_shown, want.digit_shown));
      end
    end
    out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // watchdog on cycles with no request moving on any channel
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles, %0d bits outstanding",
                 idle_cycles, frame_bits_due.size());
        $display("multiplexed_seven_segment_driver: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int i;
    rst_ni                     = 1'b0;
    cmd_if.valid               = 1'b0;
    cmd_if.mode                = MODE_DECIMAL;
    cmd_if.value               = '0;
    cfg_if.valid               = 1'b0;
    cfg_if.decimal_point_digit = DP_RESET;
    out_if.ready               = 1'b0;
    for (i = 0; i < NUM_DIGITS_DEF; i++) shown_segments[i] = SEG_OFF;
    scan_digit  = '0;
    point_digit = DP_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(0, 0, 2'd1, 34);
    test_random_traffic(77, 0, 2'd3, 34);
    test_random_traffic(0, 77, 2'd0, 34);
    test_random_traffic(30, 30, 2'd2, 34);

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d display updates, %0d refresh ticks, %0d unused codes",
             update_count, tick_count, ignored_count);
    $display("%0d frame bits checked over all four decimal point digits and four idling mixes",
             bits_checked);
    if (error_count == 0) begin
      $display("multiplexed_seven_segment_driver: match");
    end else begin
      $display("%0d mismatches", error_count);
      $display("multiplexed_seven_segment_driver: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/msd_pkg.sv
rtl/core/msd_cmd_if.sv
rtl/core/msd_cfg_if.sv
rtl/core/msd_out_if.sv
rtl/core/msd_fifo.sv
rtl/core/msd_front.sv
rtl/core/msd_back.sv
rtl/core/multiplexed_seven_segment_driver.sv
tb/multiplexed_seven_segment_driver_tb.sv
